// ----- rtl/wtc_pkg.sv -----
// Shared types and constants for the whitespace token classifier.
package wtc_pkg;

    localparam longint unsigned MAX_TEXT_OFFSET = 65535;
    localparam int OFFSET_W = 16;
    localparam logic [OFFSET_W-1:0] OFFSET_CAP =
        (MAX_TEXT_OFFSET > 64'd65535) ? 16'hFFFF : OFFSET_W'(MAX_TEXT_OFFSET);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic KIND_NUMBER = 1'b0;
    localparam logic KIND_STRING = 1'b1;

    typedef enum logic [1:0] {
        CLS_SPACE,
        CLS_DIGIT,
        CLS_OTHER,
        CLS_END
    } char_class_t;

    typedef struct packed {
        char_class_t         cls;
        logic [3:0]          digit;
        logic [OFFSET_W-1:0] offset;
    } char_entry_t;

    function automatic logic [OFFSET_W-1:0] sat_inc(input logic [OFFSET_W-1:0] v);
        sat_inc = (v >= OFFSET_CAP) ? OFFSET_CAP : v + 1'b1;
    endfunction

endpackage

// ----- rtl/wtc_if.sv -----
// Valid/ready channel interfaces for text input and token output.
interface wtc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source(output valid, output text_byte, output end_of_text, input ready);
    modport sink(input valid, input text_byte, input end_of_text, output ready);
endinterface

interface wtc_out_if;
    logic        valid;
    logic        ready;
    logic        token_kind;
    logic [63:0] number_value;
    logic [15:0] token_start;
    logic [15:0] token_length;

    modport source(output valid, output token_kind, output number_value,
                   output token_start, output token_length, input ready);
    modport sink(input valid, input token_kind, input number_value,
                 input token_start, input token_length, output ready);
endinterface

// ----- rtl/wtc_front.sv -----
// Front end: classifies each text beat and tags it with its byte offset.
module wtc_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    wtc_in_if.sink               text_in,
    input  logic                 queue_full,
    output logic                 push,
    output wtc_pkg::char_entry_t push_entry
);

    logic [wtc_pkg::OFFSET_W-1:0] byte_offset_reg;
    logic [wtc_pkg::OFFSET_W-1:0] byte_offset_next;

    assign text_in.ready = !queue_full;
    assign push          = text_in.valid && !queue_full;

    always_comb
    begin
        push_entry.offset = byte_offset_reg;
        push_entry.digit  = text_in.text_byte[3:0];
        if (text_in.end_of_text)
        begin
            push_entry.cls = wtc_pkg::CLS_END;
        end
        else if (text_in.text_byte inside {[8'd9:8'd13], 8'd32})
        begin
            push_entry.cls = wtc_pkg::CLS_SPACE;
        end
        else if (text_in.text_byte inside {[8'd48:8'd57]})
        begin
            push_entry.cls = wtc_pkg::CLS_DIGIT;
        end
        else
        begin
            push_entry.cls = wtc_pkg::CLS_OTHER;
        end
    end

    always_comb
    begin
        byte_offset_next = byte_offset_reg;
        if (push)
        begin
            if (text_in.end_of_text)
            begin
                byte_offset_next = '0;
            end
            else
            begin
                byte_offset_next = wtc_pkg::sat_inc(byte_offset_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg <= '0;
        end
        else
        begin
            byte_offset_reg <= byte_offset_next;
        end
    end

endmodule

// ----- rtl/wtc_queue.sv -----
// Short queue of classified beats between the front and back ends.
module wtc_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  wtc_pkg::char_entry_t push_entry,
    input  logic                 pop,
    output logic                 full,
    output logic                 head_valid,
    output wtc_pkg::char_entry_t head_entry
);

    wtc_pkg::char_entry_t                slot_reg [wtc_pkg::QUEUE_DEPTH];
    logic [wtc_pkg::QUEUE_PTR_W-1:0]     wr_ptr_reg;
    logic [wtc_pkg::QUEUE_PTR_W-1:0]     wr_ptr_next;
    logic [wtc_pkg::QUEUE_PTR_W-1:0]     rd_ptr_reg;
    logic [wtc_pkg::QUEUE_PTR_W-1:0]     rd_ptr_next;
    logic [wtc_pkg::QUEUE_CNT_W-1:0]     count_reg;
    logic [wtc_pkg::QUEUE_CNT_W-1:0]     count_next;

    assign full       = (count_reg == wtc_pkg::QUEUE_CNT_W'(wtc_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    function automatic logic [wtc_pkg::QUEUE_PTR_W-1:0] ptr_inc(
        input logic [wtc_pkg::QUEUE_PTR_W-1:0] p);
        ptr_inc = (p == wtc_pkg::QUEUE_PTR_W'(wtc_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/wtc_back.sv -----
// Back end: tracks the open token, parses digits and registers descriptors.
module wtc_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  wtc_pkg::char_entry_t head_entry,
    output logic                 pop,
    wtc_out_if.source            token_out
);

    logic                         in_token_reg;
    logic                         in_token_next;
    logic                         all_digits_reg;
    logic                         all_digits_next;
    logic                         overflowed_reg;
    logic                         overflowed_next;
    logic [63:0]                  accumulator_reg;
    logic [63:0]                  accumulator_next;
    logic [wtc_pkg::OFFSET_W-1:0] start_offset_reg;
    logic [wtc_pkg::OFFSET_W-1:0] start_offset_next;
    logic [wtc_pkg::OFFSET_W-1:0] token_len_reg;
    logic [wtc_pkg::OFFSET_W-1:0] token_len_next;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         out_kind_reg;
    logic [63:0]                  out_value_reg;
    logic [wtc_pkg::OFFSET_W-1:0] out_start_reg;
    logic [wtc_pkg::OFFSET_W-1:0] out_len_reg;

    logic        closes;
    logic        emits;
    logic        out_free;
    logic        is_number;
    logic [67:0] scaled_sum;

    assign closes    = (head_entry.cls == wtc_pkg::CLS_SPACE) ||
                       (head_entry.cls == wtc_pkg::CLS_END);
    assign emits     = head_valid && closes && in_token_reg;
    assign out_free  = !out_valid_reg || token_out.ready;
    assign pop       = head_valid && (!emits || out_free);
    assign is_number = all_digits_reg && !overflowed_reg;

    assign scaled_sum = {1'b0, accumulator_reg, 3'b000} + {3'b000, accumulator_reg, 1'b0}
                        + {64'd0, head_entry.digit};

    always_comb
    begin
        in_token_next     = in_token_reg;
        all_digits_next   = all_digits_reg;
        overflowed_next   = overflowed_reg;
        accumulator_next  = accumulator_reg;
        start_offset_next = start_offset_reg;
        token_len_next    = token_len_reg;
        if (pop)
        begin
            if (closes)
            begin
                in_token_next    = 1'b0;
                all_digits_next  = 1'b1;
                overflowed_next  = 1'b0;
                accumulator_next = '0;
                token_len_next   = '0;
            end
            else
            begin
                in_token_next  = 1'b1;
                token_len_next = wtc_pkg::sat_inc(token_len_reg);
                if (!in_token_reg)
                begin
                    start_offset_next = head_entry.offset;
                end
                if (head_entry.cls == wtc_pkg::CLS_DIGIT)
                begin
                    if (is_number)
                    begin
                        if (scaled_sum[67:64] != 4'd0)
                        begin
                            overflowed_next = 1'b1;
                        end
                        else
                        begin
                            accumulator_next = scaled_sum[63:0];
                        end
                    end
                end
                else
                begin
                    all_digits_next = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !token_out.ready;
        if (pop && emits)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_token_reg     <= 1'b0;
            all_digits_reg   <= 1'b1;
            overflowed_reg   <= 1'b0;
            accumulator_reg  <= '0;
            start_offset_reg <= '0;
            token_len_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            in_token_reg     <= in_token_next;
            all_digits_reg   <= all_digits_next;
            overflowed_reg   <= overflowed_next;
            accumulator_reg  <= accumulator_next;
            start_offset_reg <= start_offset_next;
            token_len_reg    <= token_len_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emits)
        begin
            out_kind_reg  <= is_number ? wtc_pkg::KIND_NUMBER : wtc_pkg::KIND_STRING;
            out_value_reg <= is_number ? accumulator_reg : 64'd0;
            out_start_reg <= start_offset_reg;
            out_len_reg   <= token_len_reg;
        end
    end

    assign token_out.valid        = out_valid_reg;
    assign token_out.token_kind   = out_kind_reg;
    assign token_out.number_value = out_value_reg;
    assign token_out.token_start  = out_start_reg;
    assign token_out.token_length = out_len_reg;

endmodule

// ----- rtl/whitespace_token_classifier_core.sv -----
// Top level of the whitespace token classifier.
// The block takes one text byte per cycle while input ready is high, and emits
// one descriptor per whitespace-separated token when the token closes, either
// as a number (all decimal digits, value within 64 bits) or as a string given
// by start offset and length. Sustained rate is one byte per cycle while the
// output side takes descriptors; a descriptor for a closing beat is registered
// in the two-entry classification queue and then in the output register. Input
// ready drops only when that queue is full, which happens only while the
// output side holds off a pending descriptor.
module whitespace_token_classifier_core
(
    input  logic       clk,
    input  logic       rst_n,
    wtc_in_if.sink     text_in,
    wtc_out_if.source  token_out
);

    logic                 push;
    logic                 pop;
    logic                 queue_full;
    logic                 head_valid;
    wtc_pkg::char_entry_t push_entry;
    wtc_pkg::char_entry_t head_entry;

    wtc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_in),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    wtc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    wtc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .token_out  (token_out)
    );

endmodule

// ----- rtl/wtc_checker.sv -----
// Port-level checks for the whitespace token classifier core.
module wtc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        token_kind,
    input logic [63:0] number_value,
    input logic [15:0] token_length
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("Output beat dropped before it was taken.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == wtc_pkg::KIND_STRING |-> number_value == 64'd0)
        else $error("String token carries a nonzero number value.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_length != 16'd0)
        else $error("Token descriptor has zero length.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("Input stalled with no descriptor waiting at the output.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("Descriptor appeared without a closing input beat.");

endmodule

bind whitespace_token_classifier_core wtc_checker u_wtc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (text_in.valid),
    .in_ready     (text_in.ready),
    .out_valid    (token_out.valid),
    .out_ready    (token_out.ready),
    .token_kind   (token_out.token_kind),
    .number_value (token_out.number_value),
    .token_length (token_out.token_length)
);

// ----- tb/tb_whitespace_token_classifier_core.sv -----
// Self-checking testbench for the whitespace token classifier core.
`timescale 1ns / 100ps

module tb_whitespace_token_classifier_core;

    typedef struct {
        logic        kind;
        logic [63:0] value;
        logic [15:0] start;
        logic [15:0] length;
    } token_desc_t;

    class token_scoreboard;
        logic        in_token;
        logic        all_digits;
        logic        overflowed;
        logic [63:0] accumulator;
        logic [15:0] byte_offset;
        logic [15:0] start_offset;
        logic [15:0] token_len;
        token_desc_t expected_tokens[$];
        int          errors;
        int          numbers_seen;
        int          strings_seen;

        function new();
            errors       = 0;
            numbers_seen = 0;
            strings_seen = 0;
            byte_offset  = '0;
            start_offset = '0;
            clear_token();
        endfunction

        function void clear_token();
            in_token    = 1'b0;
            all_digits  = 1'b1;
            overflowed  = 1'b0;
            accumulator = '0;
            token_len   = '0;
        endfunction

        function logic [15:0] capped_next(logic [15:0] v);
            return (v >= wtc_pkg::OFFSET_CAP) ? wtc_pkg::OFFSET_CAP : v + 16'd1;
        endfunction

        function void close_token();
            token_desc_t desc;
            if (in_token)
            begin
                desc.kind   = (all_digits && !overflowed) ? wtc_pkg::KIND_NUMBER
                                                          : wtc_pkg::KIND_STRING;
                desc.value  = (desc.kind == wtc_pkg::KIND_NUMBER) ? accumulator : 64'd0;
                desc.start  = start_offset;
                desc.length = token_len;
                expected_tokens.push_back(desc);
            end
            clear_token();
        endfunction

        function void note_beat(logic [7:0] b, logic e);
            logic [63:0] d;
            if (e)
            begin
                close_token();
                byte_offset = '0;
                return;
            end
            if ((b >= 8'd9 && b <= 8'd13) || b == 8'd32)
            begin
                close_token();
            end
            else
            begin
                if (!in_token)
                begin
                    clear_token();
                    in_token     = 1'b1;
                    start_offset = byte_offset;
                end
                token_len = capped_next(token_len);
                if (b >= "0" && b <= "9")
                begin
                    if (all_digits && !overflowed)
                    begin
                        d = {60'd0, b[3:0]};
                        if (accumulator > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10)
                            overflowed = 1'b1;
                        else
                            accumulator = accumulator * 64'd10 + d;
                    end
                end
                else
                begin
                    all_digits = 1'b0;
                end
            end
            byte_offset = capped_next(byte_offset);
        endfunction

        function void check_token(logic kind, logic [63:0] value, logic [15:0] start,
                                  logic [15:0] length);
            token_desc_t want;
            if (expected_tokens.size() == 0)
            begin
                $error("unexpected token: kind %0d value %0d start %0d length %0d",
                       kind, value, start, length);
                errors++;
                return;
            end
            want = expected_tokens.pop_front();
            if (kind !== want.kind)
            begin
                $error("token_kind: expected %0d, actual %0d", want.kind, kind);
                errors++;
            end
            if (value !== want.value)
            begin
                $error("number_value: expected %0d, actual %0d", want.value, value);
                errors++;
            end
            if (start !== want.start)
            begin
                $error("token_start: expected %0d, actual %0d", want.start, start);
                errors++;
            end
            if (length !== want.length)
            begin
                $error("token_length: expected %0d, actual %0d", want.length, length);
                errors++;
            end
            if (want.kind == wtc_pkg::KIND_NUMBER)
                numbers_seen++;
            else
                strings_seen++;
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    wtc_in_if  text_if();
    wtc_out_if token_if();

    whitespace_token_classifier_core DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_if),
        .token_out (token_if)
    );

    token_scoreboard sb = new();
    int burst_left = 0;
    int beats_sent = 0;

    always #6 clk = ~clk;

    task automatic send_beat(input logic [7:0] b, input logic e);
        int gap;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            if (gap > 0)
            begin
                text_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        text_if.valid       <= 1'b1;
        text_if.text_byte   <= b;
        text_if.end_of_text <= e;
        do
            @(posedge clk);
        while (text_if.ready !== 1'b1);
        burst_left--;
        beats_sent++;
        sb.note_beat(b, e);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
    endtask

    task automatic send_space_run();
        int n;
        logic [7:0] ws;
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            ws = ($urandom_range(0, 5) == 0) ? 8'd32 : 8'($urandom_range(9, 13));
            send_beat(ws, 1'b0);
        end
    endtask

    task automatic send_digits(input int n);
        repeat (n)
            send_beat(8'("0" + $urandom_range(0, 9)), 1'b0);
    endtask

    task automatic send_word(input int n);
        logic [7:0] b;
        repeat (n)
        begin
            if ($urandom_range(0, 9) < 3)
            begin
                b = 8'("0" + $urandom_range(0, 9));
            end
            else
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while ((b >= 8'd9 && b <= 8'd13) || b == 8'd32);
            end
            send_beat(b, 1'b0);
        end
    endtask

    task automatic wait_drained();
        text_if.valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        burst_left = 0;
    endtask

    initial
    begin
        int pick;
        int random_end;
        rst_n               = 1'b0;
        text_if.valid       = 1'b0;
        text_if.text_byte   = 8'd0;
        text_if.end_of_text = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("0");
        send_beat(8'd32, 1'b0);
        send_text("18446744073709551615");
        send_beat(8'd9, 1'b0);
        send_text("18446744073709551616");
        send_beat(8'd10, 1'b0);
        send_text("12a");
        send_beat(8'd11, 1'b0);
        send_text("a12");
        send_beat(8'd12, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h08, 1'b0);
        send_beat(8'h0E, 1'b0);
        send_beat(8'h1F, 1'b0);
        send_beat(8'h21, 1'b0);
        send_beat(8'h2F, 1'b0);
        send_beat(8'h3A, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'd13, 1'b0);
        send_text("007");
        send_beat(8'h31, 1'b1);
        send_beat(8'hFF, 1'b1);
        send_beat(8'd32, 1'b0);
        send_beat(8'h20, 1'b1);
        send_text("abc");
        send_beat(8'd32, 1'b0);
        send_text("7");
        send_beat(8'h00, 1'b1);

        wait_drained();

        random_end = beats_sent + 1150;
        while (beats_sent < random_end)
        begin
            if (beats_sent > random_end - 800 && beats_sent < random_end - 790)
                wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                send_digits(($urandom_range(0, 5) == 0) ? $urandom_range(18, 22)
                                                        : $urandom_range(1, 6));
            end
            else if (pick < 60)
            begin
                send_word($urandom_range(1, 8));
            end
            else if (pick < 70)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    send_text("1844674407370955161");
                    send_digits(1);
                end
                else
                begin
                    send_text("184467440737095516");
                    send_digits(2);
                end
            end
            else if (pick < 82)
            begin
                repeat ($urandom_range(1, 6))
                    send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
            if ($urandom_range(0, 6) == 0)
                send_beat(8'($urandom_range(0, 255)), 1'b1);
            else
                send_space_run();
        end

        text_if.valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Run covered %0d text beats and %0d tokens (%0d numbers, %0d strings).",
                 beats_sent, sb.numbers_seen + sb.strings_seen, sb.numbers_seen,
                 sb.strings_seen);
        $display("Stimulus included 64-bit digit overflow, all whitespace codes %s",
                 "and end markers with and without an open token.");
        if (sb.errors == 0)
            $display("whitespace_token_classifier_core: match");
        else
            $display("whitespace_token_classifier_core: mismatch");
        $finish;
    end

    initial
    begin
        int hold;
        int mode;
        int cyc;
        hold = 0;
        mode = 0;
        cyc  = 0;
        token_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && token_if.valid === 1'b1 && token_if.ready === 1'b1)
                sb.check_token(token_if.token_kind, token_if.number_value,
                               token_if.token_start, token_if.token_length);
            if (hold <= 0)
            begin
                mode = $urandom_range(0, 3);
                hold = $urandom_range(16, 200);
            end
            hold--;
            cyc++;
            case (mode)
                0: token_if.ready <= 1'b1;
                1: token_if.ready <= 1'($urandom_range(0, 1));
                2: token_if.ready <= ($urandom_range(0, 7) == 0);
                default: token_if.ready <= (cyc % 5 != 0);
            endcase
        end
    end

    initial
    begin
        #10_000_000;
        $display("whitespace_token_classifier_core: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/wtc_pkg.sv
rtl/wtc_if.sv
rtl/wtc_front.sv
rtl/wtc_queue.sv
rtl/wtc_back.sv
rtl/whitespace_token_classifier_core.sv
rtl/wtc_checker.sv
tb/tb_whitespace_token_classifier_core.sv
